/* rtl/hpt_pkg.sv */
`timescale 1ns / 1ps
package hpt_pkg;
	localparam int NUM_REGS = 8;
	localparam int REG_IDX_W = 3;
	localparam int REG_W = 64;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_M0_M1   = 3'd0,
		REG_M2_M3   = 3'd1,
		REG_M4_M5   = 3'd2,
		REG_M6_M7   = 3'd3,
		REG_M8_M9   = 3'd4,
		REG_M10_M11 = 3'd5,
		REG_M12_M13 = 3'd6,
		REG_M14_M15 = 3'd7
	} reg_idx_t;
endpackage

/* rtl/hpt_if.sv */
`timescale 1ns / 1ps
interface hpt_in_if #(parameter int DATA_WIDTH = 32) (input logic clk);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] px;
	logic signed [DATA_WIDTH-1:0] py;
	logic signed [DATA_WIDTH-1:0] pz;
	modport source (output valid, px, py, pz, input ready);
	modport sink (input valid, px, py, pz, output ready);
endinterface

/* rtl/hpt_out_if.sv */
`timescale 1ns / 1ps
interface hpt_out_if #(parameter int DATA_WIDTH = 32) (input logic clk);
	logic valid;
	logic ready;
	logic signed [DATA_WIDTH-1:0] qx;
	logic signed [DATA_WIDTH-1:0] qy;
	logic signed [DATA_WIDTH-1:0] qz;
	logic divided;
	logic saturated;
	modport source (output valid, qx, qy, qz, divided, saturated, input ready);
	modport sink (input valid, qx, qy, qz, divided, saturated, output ready);
endinterface

/* rtl/hpt_cfg_if.sv */
`timescale 1ns / 1ps
interface hpt_cfg_if (input logic clk);
	logic valid;
	logic ready;
	logic [7:0] index;
	logic [63:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/hpt_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage, magnitudes only.
module hpt_div #(
	parameter int NW = 48,
	parameter int DW = 32,
	parameter int TW = 4
) (
	input  logic clk,
	input  logic en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [TW-1:0] tag_in,
	output logic [NW-1:0] quo,
	output logic [TW-1:0] tag_out
);
	logic [NW-1:0] rem_s [0:NW];
	logic [NW-1:0] q_s [0:NW];
	logic [DW-1:0] d_s [0:NW];
	logic [TW-1:0] t_s [0:NW];

	always_comb begin
		rem_s[0] = '0;
		q_s[0] = num;
		d_s[0] = den;
		t_s[0] = tag_in;
	end

	genvar k;
	generate
		for (k = 0; k < NW; k++) begin : g_st
			logic [NW:0] trial;
			logic [NW:0] sub;
			assign trial = {rem_s[k], q_s[k][NW-1]};
			assign sub = trial - {{(NW+1-DW){1'b0}}, d_s[k]};
			always_ff @(posedge clk) begin
				if (en) begin
					if (!sub[NW]) begin
						rem_s[k+1] <= sub[NW-1:0];
						q_s[k+1] <= {q_s[k][NW-2:0], 1'b1};
					end else begin
						rem_s[k+1] <= trial[NW-1:0];
						q_s[k+1] <= {q_s[k][NW-2:0], 1'b0};
					end
					d_s[k+1] <= d_s[k];
					t_s[k+1] <= t_s[k];
				end
			end
		end
	endgenerate

	assign quo = q_s[NW];
	assign tag_out = t_s[NW];
endmodule

/* rtl/homogeneous_point_transform_core.sv */
`timescale 1ns / 1ps
// Homogeneous point transform core.
// Points enter on in_ch (px, py, pz, signed fixed point) and leave on out_ch
// as (qx, qy, qz, divided, saturated), one result per point, in order.
// The 4x4 matrix lives in eight 64-bit registers written over cfg_ch; write
// them only while no point is in flight. cfg_ch is always ready.
// Throughput is one point per cycle unless the receiver stalls a valid result.
// The pipeline has one stage of multipliers, two of row sums and saturation, then
// the divider pipeline with one quotient bit per stage, then sign and clamp.
// The whole pipeline advances together on one enable; when the receiver
// holds ready low under a valid result, the output register and every stage
// hold their items and in_ch.ready drops, so nothing is lost or repeated.
// Reset clears all valid bits and loads the identity matrix.
module homogeneous_point_transform_core #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	hpt_in_if.sink in_ch,
	hpt_out_if.source out_ch,
	hpt_cfg_if.sink cfg_ch
);
	localparam int DW = DATA_WIDTH;
	localparam int PW = 2 * DW;
	localparam int SW = PW + 3;
	localparam int NW = DW + FRAC_BITS;
	localparam int LAT = NW + 4;
	localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (DW-1)) - 1);
	localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

	logic [hpt_pkg::REG_W-1:0] regs_q [0:hpt_pkg::NUM_REGS-1];
	logic en;
	logic [LAT-1:0] vld_q;

	assign en = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[hpt_pkg::REG_M0_M1] <= 64'd65536;
			regs_q[hpt_pkg::REG_M2_M3] <= 64'd0;
			regs_q[hpt_pkg::REG_M4_M5] <= 64'h0001_0000_0000_0000;
			regs_q[hpt_pkg::REG_M6_M7] <= 64'd0;
			regs_q[hpt_pkg::REG_M8_M9] <= 64'd0;
			regs_q[hpt_pkg::REG_M10_M11] <= 64'd65536;
			regs_q[hpt_pkg::REG_M12_M13] <= 64'd0;
			regs_q[hpt_pkg::REG_M14_M15] <= 64'h0001_0000_0000_0000;
		end else if (cfg_ch.valid && cfg_ch.index < 8'(hpt_pkg::NUM_REGS)) begin
			regs_q[cfg_ch.index[hpt_pkg::REG_IDX_W-1:0]] <= cfg_ch.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_ch.valid};
		end
	end

	function automatic logic signed [DW-1:0] ent(input logic [63:0] r, input logic hi);
		logic [31:0] h;
		h = hi ? r[63:32] : r[31:0];
		return $signed(h[DW-1:0]);
	endfunction

	// Stage 1: twelve products and the four offsets.
	logic signed [PW-1:0] prod_s1 [0:3][0:2];
	logic signed [PW-1:0] off_s1 [0:3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				prod_s1[r][0] <= PW'(ent(regs_q[2*r], 1'b0)) * PW'(in_ch.px);
				prod_s1[r][1] <= PW'(ent(regs_q[2*r], 1'b1)) * PW'(in_ch.py);
				prod_s1[r][2] <= PW'(ent(regs_q[2*r+1], 1'b0)) * PW'(in_ch.pz);
				off_s1[r] <= PW'(ent(regs_q[2*r+1], 1'b1)) <<< FRAC_BITS;
			end
		end
	end

	// Stage 2: exact row sums, floor shift.
	logic signed [SW-1:0] sum_s2 [0:3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				sum_s2[r] <= (SW'(prod_s1[r][0]) + SW'(prod_s1[r][1]) + SW'(prod_s1[r][2])
					+ SW'(off_s1[r])) >>> FRAC_BITS;
			end
		end
	end

	// Stage 3: saturate rows, prepare divider operands.
	logic signed [DW-1:0] v_s3 [0:3];
	logic sat_s3;
	always_ff @(posedge clk) begin
		logic s;
		if (en) begin
			s = 1'b0;
			for (int r = 0; r < 4; r++) begin
				if (sum_s2[r] > MAXV) begin
					v_s3[r] <= MAXV[DW-1:0];
					s = 1'b1;
				end else if (sum_s2[r] < MINV) begin
					v_s3[r] <= MINV[DW-1:0];
					s = 1'b1;
				end else begin
					v_s3[r] <= sum_s2[r][DW-1:0];
				end
			end
			sat_s3 <= s;
		end
	end

	logic [DW-1:0] dmag;
	logic dz;
	logic [NW-1:0] nmag [0:2];
	logic [NW-1:0] qmag [0:2];
	localparam int TW = 3 * DW + 3;
	logic [TW-1:0] tag_o [0:2];
	logic [TW-1:0] tag_i;
	assign dz = v_s3[3] == '0;
	assign dmag = v_s3[3][DW-1] ? DW'(-v_s3[3]) : v_s3[3];
	assign tag_i = {v_s3[0], v_s3[1], v_s3[2], sat_s3, dz, v_s3[3][DW-1]};

	genvar g;
	generate
		for (g = 0; g < 3; g++) begin : g_div
			logic signed [NW-1:0] nn;
			assign nn = NW'(v_s3[g]) <<< FRAC_BITS;
			assign nmag[g] = nn[NW-1] ? NW'(-nn) : NW'(nn);
			hpt_div #(.NW(NW), .DW(DW), .TW(TW)) u_div (
				.clk(clk), .en(en), .num(nmag[g]), .den(dz ? DW'(1) : dmag),
				.tag_in(tag_i), .quo(qmag[g]), .tag_out(tag_o[g])
			);
		end
	endgenerate

	// Final stage: sign, clamp and select.
	logic signed [DW-1:0] qx_q, qy_q, qz_q;
	logic div_q, sat_q;
	always_ff @(posedge clk) begin
		logic s;
		logic [DW-1:0] res [0:2];
		logic signed [NW:0] sq;
		logic [TW-1:0] t;
		if (en) begin
			t = tag_o[0];
			s = t[2];
			for (int i = 0; i < 3; i++) begin
				sq = (t[0] ^ t[TW-1-DW*i]) ? -$signed({1'b0, qmag[i]}) : $signed({1'b0, qmag[i]});
				if (t[1]) begin
					res[i] = t[TW-1-DW*i -: DW];
				end else if (sq > (NW+1)'(MAXV)) begin
					res[i] = MAXV[DW-1:0];
					s = 1'b1;
				end else if (sq < (NW+1)'(MINV)) begin
					res[i] = MINV[DW-1:0];
					s = 1'b1;
				end else begin
					res[i] = sq[DW-1:0];
				end
			end
			qx_q <= res[0];
			qy_q <= res[1];
			qz_q <= res[2];
			div_q <= !t[1];
			sat_q <= s;
		end
	end

	assign out_ch.qx = qx_q;
	assign out_ch.qy = qy_q;
	assign out_ch.qz = qz_q;
	assign out_ch.divided = div_q;
	assign out_ch.saturated = sat_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.qx))
		else $error("result changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == (!out_ch.valid || out_ch.ready))
		else $error("input ready inconsistent with output stall");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> vld_q[0])
		else $error("accepted item not tracked");
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
module tb;
	localparam int DW = 32;
	localparam int FB = 16;
	localparam int PIPE_LAT = 4 + DW + FB;

	typedef struct packed {
		logic [DW-1:0] qx;
		logic [DW-1:0] qy;
		logic [DW-1:0] qz;
		logic divided;
		logic saturated;
	} point_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hpt_in_if #(.DATA_WIDTH(DW)) in_ch (clk);
	hpt_out_if #(.DATA_WIDTH(DW)) out_ch (clk);
	hpt_cfg_if cfg_ch (clk);

	homogeneous_point_transform_core #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_ch(cfg_ch)
	);

	always #5 clk = ~clk;

	logic [63:0] matrix [hpt_pkg::NUM_REGS];
	point_result_t pending_points [$];
	int mismatches = 0;
	int points_sent = 0;
	int results_seen = 0;
	int divided_seen = 0;
	int saturated_seen = 0;
	bit gaps_on = 1'b0;
	bit stalls_on = 1'b0;
	int hold_cycles = 0;
	int stall_left = 0;

	function automatic longint matrix_entry(int n);
		logic [63:0] r;
		r = matrix[n / 2];
		return (n % 2) ? longint'($signed(r[63:32])) : longint'($signed(r[31:0]));
	endfunction

	function automatic longint clamp_to_word(logic signed [95:0] v, ref bit sat);
		logic signed [95:0] hi;
		logic signed [95:0] lo;
		hi = 96'sd2147483647;
		lo = -96'sd2147483648;
		if (v > hi) begin
			sat = 1'b1;
			return 64'sd2147483647;
		end
		if (v < lo) begin
			sat = 1'b1;
			return -64'sd2147483648;
		end
		return longint'(v);
	endfunction

	function automatic point_result_t transform_point(logic [DW-1:0] x, logic [DW-1:0] y,
			logic [DW-1:0] z);
		longint p [3];
		longint v [4];
		logic signed [95:0] acc;
		longint num;
		bit sat;
		point_result_t res;
		sat = 1'b0;
		p[0] = longint'($signed(x));
		p[1] = longint'($signed(y));
		p[2] = longint'($signed(z));
		for (int r = 0; r < 4; r++) begin
			acc = matrix_entry(r * 4 + 3);
			acc = acc <<< FB;
			for (int i = 0; i < 3; i++)
				acc = acc + (matrix_entry(r * 4 + i) * p[i]);
			acc = acc >>> FB;
			v[r] = clamp_to_word(acc, sat);
		end
		res.divided = (v[3] != 0);
		if (v[3] != 0) begin
			for (int i = 0; i < 3; i++) begin
				num = v[i] * 65536;
				acc = num / v[3];
				v[i] = clamp_to_word(acc, sat);
			end
		end
		res.qx = v[0][DW-1:0];
		res.qy = v[1][DW-1:0];
		res.qz = v[2][DW-1:0];
		res.saturated = sat;
		return res;
	endfunction

	// Receiver: long hold-offs take priority over random stall bursts.
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_ch.ready <= 1'b0;
				hold_cycles--;
			end else if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
				if (stalls_on && $urandom_range(0, 4) == 0)
					stall_left = $urandom_range(1, 7);
			end
		end
	end

	always @(posedge clk) begin
		point_result_t want;
		point_result_t got;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got = {out_ch.qx, out_ch.qy, out_ch.qz, out_ch.divided, out_ch.saturated};
			results_seen++;
			if (got.divided) divided_seen++;
			if (got.saturated) saturated_seen++;
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result item %h", got);
			end else begin
				want = pending_points.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp q=%h,%h,%h div=%b sat=%b got q=%h,%h,%h div=%b sat=%b",
							want.qx, want.qy, want.qz, want.divided, want.saturated,
							got.qx, got.qy, got.qz, got.divided, got.saturated);
				end
			end
		end
	end

	task automatic write_reg(logic [7:0] idx, logic [63:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx < hpt_pkg::NUM_REGS)
			matrix[idx[hpt_pkg::REG_IDX_W-1:0]] = value;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_point(logic [DW-1:0] x, logic [DW-1:0] y, logic [DW-1:0] z);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.px <= x;
		in_ch.py <= y;
		in_ch.pz <= z;
		do @(posedge clk); while (!in_ch.ready);
		pending_points.push_back(transform_point(x, y, z));
		points_sent++;
	endtask

	task automatic drain;
		in_ch.valid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 8) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
			3: return 32'($signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000) <<< 4;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [63:0] rand_pair(bit tame);
		logic [31:0] lo;
		logic [31:0] hi;
		if (tame) begin
			lo = 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
			hi = 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
		end else begin
			lo = rand_word();
			hi = rand_word();
		end
		return {hi, lo};
	endfunction

	task automatic test_identity_extremes;
		logic [31:0] pts [6];
		pts = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001};
		for (int i = 0; i < 6; i++)
			send_point(pts[i], pts[(i + 1) % 6], pts[(i + 3) % 6]);
		drain();
	endtask

	task automatic test_zero_w;
		write_reg(8'(hpt_pkg::REG_M12_M13), 64'h0);
		write_reg(8'(hpt_pkg::REG_M14_M15), 64'h0);
		send_point(32'h0003_0000, 32'hFFFD_0000, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h0, 32'h1234_5678);
		drain();
	endtask

	task automatic test_register_extremes;
		for (int r = 0; r < hpt_pkg::NUM_REGS; r++)
			write_reg(8'(r), 64'hFFFF_FFFF_FFFF_FFFF);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
		send_point(32'h0, 32'h0, 32'h0);
		drain();
		for (int r = 0; r < hpt_pkg::NUM_REGS; r++)
			write_reg(8'(r), 64'h7FFF_FFFF_8000_0000);
		send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_point(32'h8000_0000, 32'h0002_0000, 32'hFFFF_0000);
		drain();
		for (int r = 0; r < hpt_pkg::NUM_REGS; r++)
			write_reg(8'(r), 64'h0);
		send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
		drain();
		// Tiny w makes the quotients overflow.
		write_reg(8'(hpt_pkg::REG_M0_M1), 64'h0000_0000_0100_0000);
		write_reg(8'(hpt_pkg::REG_M14_M15), 64'h0000_0001_0000_0000);
		send_point(32'h0100_0000, 32'h0, 32'h0);
		send_point(32'hFF00_0000, 32'h0, 32'h0);
		drain();
	endtask

	task automatic test_unknown_index;
		write_reg(8'(hpt_pkg::NUM_REGS), 64'hDEAD_BEEF_DEAD_BEEF);
		write_reg(8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
		write_reg(8'h55, 64'h1);
		send_point(32'h0002_0000, 32'h0003_0000, 32'h0004_0000);
		drain();
	endtask

	task automatic load_random_matrix(bit tame);
		for (int r = 0; r < hpt_pkg::NUM_REGS; r++)
			write_reg(8'(r), rand_pair(tame));
		// Keep w well away from zero most of the time.
		if (tame && $urandom_range(0, 3) != 0)
			write_reg(8'(hpt_pkg::REG_M14_M15),
				{32'($urandom_range(32'h0001_0000, 32'h0008_0000)),
				matrix[hpt_pkg::REG_M14_M15][31:0]});
	endtask

	task automatic test_random_points(int phases, int per_phase);
		for (int ph = 0; ph < phases; ph++) begin
			load_random_matrix($urandom_range(0, 3) != 0);
			for (int i = 0; i < per_phase; i++)
				send_point(rand_word(), rand_word(), rand_word());
			drain();
		end
	endtask

	task automatic test_backpressure;
		load_random_matrix(1'b1);
		hold_cycles = 300;
		for (int i = 0; i < 120; i++)
			send_point(rand_word(), rand_word(), rand_word());
		drain();
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.px = '0;
		in_ch.py = '0;
		in_ch.pz = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		matrix = '{64'd65536, 64'd0, 64'd281474976710656, 64'd0,
			64'd0, 64'd65536, 64'd0, 64'd281474976710656};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity_extremes();
		test_zero_w();
		test_register_extremes();
		test_unknown_index();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
		test_random_points(12, 80);
		test_backpressure();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		test_random_points(4, 80);

		$display("Sent %0d points over many matrices, with zero w, unknown writes,",
			points_sent);
		$display("and back-pressure; %0d results, %0d divided, %0d saturated.",
			results_seen, divided_seen, saturated_seen);
		if (mismatches == 0 && pending_points.size() == 0) begin
			$display("homogeneous_point_transform_core test passed");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches,
				pending_points.size());
			$display("homogeneous_point_transform_core test failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout with %0d results outstanding", pending_points.size());
		$display("homogeneous_point_transform_core test failed");
		$finish;
	end
endmodule

/* homogeneous_point_transform_core.f */
rtl/hpt_pkg.sv
rtl/hpt_if.sv
rtl/hpt_out_if.sv
rtl/hpt_cfg_if.sv
rtl/hpt_div.sv
rtl/homogeneous_point_transform_core.sv
tb/tb.sv
